// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both sample on clk and go quiet in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold at the next edge after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/smre_pkg.sv =====
package smre_pkg;

  localparam int CFG_W    = 10;
  localparam int SAMPLE_W = 8;
  localparam int STRIP_W  = 8;
  localparam int COL_W    = 9;
  localparam int LEVEL_W  = 8;

  localparam logic [CFG_W-1:0]    WIDTH_RESET = CFG_W'(400);
  localparam logic [LEVEL_W-1:0]  THRESH_RESET = LEVEL_W'(77);

  // result queue depth, room for two full items
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);

  typedef enum logic [0:0] {
    REG_ACTIVE_WIDTH   = 1'b0,
    REG_ZERO_THRESHOLD = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [STRIP_W-1:0] strip;
    logic [COL_W-1:0]   first;
    logic [COL_W-1:0]   final_col;
    logic [LEVEL_W-1:0] level;
    logic               done;
  } run_t;

  // runs produced by one item; run1 is the strip's closing run
  typedef struct packed {
    logic en0;
    logic en1;
    run_t run0;
    run_t run1;
  } push_t;

endpackage

// ===== rtl/core/smre_colmem.sv =====
// Column maximum store: one write port, one read port, registered read.
// A read that meets a write to the same entry returns the new data.
module smre_colmem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [smre_pkg::LEVEL_W-1:0]  rd_data,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [smre_pkg::LEVEL_W-1:0]  wr_data
);
  import smre_pkg::*;

  logic [LEVEL_W-1:0] mem [DEPTH];
  logic [LEVEL_W-1:0] ram_q;
  logic [LEVEL_W-1:0] byp_data;
  logic               byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      ram_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : ram_q;

endmodule

// ===== rtl/core/smre_outq.sv =====
// Small result queue: takes up to two runs a cycle, hands out one while out_ready is high.
module smre_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  smre_pkg::push_t               push,
  output logic [smre_pkg::OQ_PW:0]      count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output smre_pkg::run_t                out_run
);
  import smre_pkg::*;

  run_t             q [OQ_DEPTH];
  logic [OQ_PW-1:0] wr_ptr;
  logic [OQ_PW-1:0] rd_ptr;
  logic             pop;
  logic [OQ_PW:0]   n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_run   = q[rd_ptr];
  assign n_push    = (OQ_PW+1)'(push.en0) + (OQ_PW+1)'(push.en1);

  always_ff @(posedge clk) begin
    if (push.en0) begin
      q[wr_ptr] <= push.run0;
      if (push.en1) begin
        q[wr_ptr + OQ_PW'(1)] <= push.run1;
      end
    end else if (push.en1) begin
      q[wr_ptr] <= push.run1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PW'(1);
      end
      count <= count + n_push - (OQ_PW+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/strip_max_run_length_encoder_top.sv =====
// Strip max run-length encoder, top level.
// Throughput: one sample word per cycle unless input stalls; runs leave at one word per cycle
// while out_ready is high. A closing run passes stage 1 and the run queue to the output.
// Input stalls while a word waits in stage 1 and the 4-entry run queue holds over two runs.
// Reset (rst, synchronous): counters, open run, queue and config go to reset values.
// The column store is not cleared; entries are reloaded on each strip's first row.
`include "assert_macros.svh"

module strip_max_run_length_encoder_top #(
  parameter int ROWS_PER_STRIP = 8,
  parameter int MAX_COLUMNS    = 512,
  parameter int MAX_STRIPS     = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  // sample words in raster order
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [smre_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           frame_start,
  // run words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [smre_pkg::STRIP_W-1:0]   strip_index,
  output logic [smre_pkg::COL_W-1:0]     run_first,
  output logic [smre_pkg::COL_W-1:0]     run_final,
  output logic [smre_pkg::LEVEL_W-1:0]   run_level,
  output logic                           strip_done,
  // config writes, only while idle
  input  logic                           cfg_wr_en,
  input  smre_pkg::reg_index_t           cfg_index,
  input  logic [smre_pkg::CFG_W-1:0]     cfg_data
);
  import smre_pkg::*;

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int RW = (ROWS_PER_STRIP > 1) ? $clog2(ROWS_PER_STRIP) : 1;
  localparam int SW = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   active_width;
  logic [LEVEL_W-1:0] zero_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width   <= WIDTH_RESET;
      zero_threshold <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ACTIVE_WIDTH:   active_width   <= cfg_data;
        REG_ZERO_THRESHOLD: zero_threshold <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position counters, store read issued on accept
  // ---------------------------------------------------------------------------
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_in_strip;
  logic [SW-1:0] strip_count;

  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [SW-1:0] strip_cur;
  logic [WW-1:0] aw_ext;
  logic [WW-1:0] width_eff;
  logic          last_col;
  logic          first_row;
  logic          last_row;
  logic          accept;

  // frame start restarts the counters before this word
  assign col_cur   = frame_start ? '0 : column_count;
  assign row_cur   = frame_start ? '0 : row_in_strip;
  assign strip_cur = frame_start ? '0 : strip_count;

  // width of 0 acts as 1, above MAX_COLUMNS acts as MAX_COLUMNS
  assign aw_ext = WW'(active_width);
  always_comb begin
    if (aw_ext == '0) begin
      width_eff = WW'(1);
    end else if (aw_ext > WW'(MAX_COLUMNS)) begin
      width_eff = WW'(MAX_COLUMNS);
    end else begin
      width_eff = aw_ext;
    end
  end

  // a column at or past the end (width shrunk mid-row) closes the row
  assign last_col  = (WW'(col_cur) + WW'(1)) >= width_eff;
  assign first_row = row_cur == '0;
  assign last_row  = row_cur >= RW'(ROWS_PER_STRIP - 1);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_in_strip <= '0;
      strip_count  <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        if (last_row) begin
          row_in_strip <= '0;
          strip_count  <= (strip_cur == SW'(MAX_STRIPS - 1)) ? '0 : strip_cur + SW'(1);
        end else begin
          row_in_strip <= row_cur + RW'(1);
          strip_count  <= strip_cur;
        end
      end else begin
        column_count <= col_cur + CW'(1);
        row_in_strip <= row_cur;
        strip_count  <= strip_cur;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: read-modify-write of the column max, run tracking
  // ---------------------------------------------------------------------------
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [CW-1:0]       s1_col;
  logic [SW-1:0]       s1_strip;
  logic                s1_first_row;
  logic                s1_last_row;
  logic                s1_last_col;
  logic                s1_go;

  logic [LEVEL_W-1:0]  stored;
  logic [LEVEL_W-1:0]  maxv;
  logic [LEVEL_W-1:0]  level;
  logic                lvl_change;

  logic [CW-1:0]       open_run_first;
  logic [LEVEL_W-1:0]  open_run_level;
  logic [CW-1:0]       open_first_next;
  logic [LEVEL_W-1:0]  open_level_next;

  logic [OQ_PW:0]      q_count;
  push_t               push;
  run_t                out_run;

  // room for the worst case of two runs
  assign s1_go    = s1_valid && (q_count <= (OQ_PW+1)'(OQ_DEPTH - 2));
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample    <= sample;
      s1_col       <= col_cur;
      s1_strip     <= strip_cur;
      s1_first_row <= first_row;
      s1_last_row  <= last_row;
      s1_last_col  <= last_col;
    end
  end

  smre_colmem #(
    .DEPTH (MAX_COLUMNS),
    .AW    (CW)
  ) u_colmem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (stored),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (maxv)
  );

  always_comb begin
    if (s1_first_row || (s1_sample > stored)) begin
      maxv = s1_sample;
    end else begin
      maxv = stored;
    end
    level      = (maxv < zero_threshold) ? '0 : maxv;
    lvl_change = (s1_col != '0) && (level != open_run_level);
    if (s1_col == '0) begin
      open_first_next = '0;
      open_level_next = level;
    end else if (lvl_change) begin
      open_first_next = s1_col;
      open_level_next = level;
    end else begin
      open_first_next = open_run_first;
      open_level_next = open_run_level;
    end
  end

  // run closed by a level change, then the strip's final run
  always_comb begin
    push.en0            = s1_go && s1_last_row && lvl_change;
    push.en1            = s1_go && s1_last_row && s1_last_col;
    push.run0.strip     = STRIP_W'(s1_strip);
    push.run0.first     = COL_W'(open_run_first);
    push.run0.final_col = COL_W'(s1_col - CW'(1));
    push.run0.level     = open_run_level;
    push.run0.done      = 1'b0;
    push.run1.strip     = STRIP_W'(s1_strip);
    push.run1.first     = COL_W'(open_first_next);
    push.run1.final_col = COL_W'(s1_col);
    push.run1.level     = open_level_next;
    push.run1.done      = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_run_first <= '0;
      open_run_level <= '0;
    end else if (s1_go && s1_last_row) begin
      open_run_first <= open_first_next;
      open_run_level <= open_level_next;
    end
  end

  smre_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .count     (q_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_run   (out_run)
  );

  assign strip_index = out_run.strip;
  assign run_first   = out_run.first;
  assign run_final   = out_run.final_col;
  assign run_level   = out_run.level;
  assign strip_done  = out_run.done;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_col_range, column_count < CW'(MAX_COLUMNS - 1) || column_count == CW'(MAX_COLUMNS - 1), "column counter out of range")
  `ASSERT_ALWAYS(a_row_range, row_in_strip < RW'(ROWS_PER_STRIP - 1) || row_in_strip == RW'(ROWS_PER_STRIP - 1), "row counter out of range")
  `ASSERT_ALWAYS(a_q_room, q_count <= (OQ_PW+1)'(OQ_DEPTH), "run queue overflow")
  `ASSERT_NEXT(a_s1_load, accept, s1_valid, "accepted word missing from stage 1")

endmodule

// ===== sim/tb_strip_max_run_length_encoder_top.sv =====
module tb_strip_max_run_length_encoder_top;
  import smre_pkg::*;

  localparam int ROWS         = 8;
  localparam int MAX_COLS     = 512;
  localparam int MAX_STRIPS   = 256;
  // a run passes stage 1 and the run queue after its word is taken; pad before touching config
  localparam int DRAIN_PAD    = 6;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_WORDS = 300;

  // ---------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample      = '0;
  logic                frame_start = 1'b0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [STRIP_W-1:0]  strip_index;
  logic [COL_W-1:0]    run_first;
  logic [COL_W-1:0]    run_final;
  logic [LEVEL_W-1:0]  run_level;
  logic                strip_done;
  logic                cfg_wr_en   = 1'b0;
  reg_index_t          cfg_index   = REG_ACTIVE_WIDTH;
  logic [CFG_W-1:0]    cfg_data    = '0;

  strip_max_run_length_encoder_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .strip_index (strip_index),
    .run_first   (run_first),
    .run_final   (run_final),
    .run_level   (run_level),
    .strip_done  (strip_done),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Encoder shadow: config, counters, open run and per-column maxima
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   mdl_width  = 10'd400;
  logic [LEVEL_W-1:0] mdl_thresh = 8'd77;
  int                 col_cnt    = 0;
  int                 row_cnt    = 0;
  int                 strip_cnt  = 0;
  int                 open_first = 0;
  logic [LEVEL_W-1:0] open_level = '0;
  logic [LEVEL_W-1:0] col_max     [MAX_COLS];
  bit                 col_written [MAX_COLS];

  // runs still owed by the DUT, oldest first
  run_t pending_runs[$];

  // stimulus shaping: target level per column, so runs actually form
  logic [LEVEL_W-1:0] col_profile [MAX_COLS];

  bit snd_idle      = 1'b1;
  bit rx_idle       = 1'b1;
  int rx_hold_cycles = 0;
  int words_sent    = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  function automatic run_t make_run(input int first_c, input int last_c,
                                    input logic [LEVEL_W-1:0] lvl, input logic done);
    run_t r;
    r.strip     = STRIP_W'(strip_cnt);
    r.first     = COL_W'(first_c);
    r.final_col = COL_W'(last_c);
    r.level     = lvl;
    r.done      = done;
    return r;
  endfunction

  // Advance the shadow by one sample word and queue the runs it closes.
  task automatic compute_runs(input logic [SAMPLE_W-1:0] s, input logic fs);
    int                 w;
    int                 c;
    logic               last_c;
    logic               first_r;
    logic               last_r;
    logic [LEVEL_W-1:0] mx;
    logic [LEVEL_W-1:0] lvl;
    if (fs) begin
      col_cnt   = 0;
      row_cnt   = 0;
      strip_cnt = 0;
    end
    // width 0 acts as 1, anything above the store acts as full width
    w = int'(mdl_width);
    if (w < 1) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    // a column at or past the last one (width shrunk mid-row) ends the row
    c      = col_cnt;
    last_c = (c >= w - 1);
    if (c >= MAX_COLS) c = MAX_COLS - 1;
    first_r = (row_cnt == 0);
    last_r  = (row_cnt >= ROWS - 1);
    // first row of a strip reloads the column, later rows take the max
    if (first_r) mx = s;
    else mx = (s > col_max[c]) ? s : col_max[c];
    col_max[c]     = mx;
    col_written[c] = 1'b1;
    if (last_r) begin
      lvl = (mx < mdl_thresh) ? '0 : mx;
      if (c == 0) begin
        open_first = 0;
        open_level = lvl;
      end else if (lvl != open_level) begin
        pending_runs.push_back(make_run(open_first, c - 1, open_level, 1'b0));
        open_first = c;
        open_level = lvl;
      end
      if (last_c) pending_runs.push_back(make_run(open_first, c, open_level, 1'b1));
    end
    if (last_c) begin
      col_cnt = 0;
      if (last_r) begin
        row_cnt   = 0;
        strip_cnt = (strip_cnt + 1) % MAX_STRIPS;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt = c + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one sample word per call, random gap in front of it while snd_idle is set
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic fs);
    int   gap;
    int   c;
    logic fs_eff;
    gap = snd_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // a strip widened mid-way would read columns never written; restart the frame
    c      = (col_cnt >= MAX_COLS) ? MAX_COLS - 1 : col_cnt;
    fs_eff = fs;
    if (!fs && row_cnt != 0 && !col_written[c]) fs_eff = 1'b1;
    in_valid    <= 1'b1;
    sample      <= s;
    frame_start <= fs_eff;
    compute_runs(s, fs_eff);
    words_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender goes quiet until every owed run is back, plus latency slack.
  task automatic drain_runs();
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Config write, only called while the block is idle.
  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_ACTIVE_WIDTH) mdl_width = val;
    else mdl_thresh = val[LEVEL_W-1:0];
  endtask

  // Levels that matter: both ends and either side of the threshold.
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return mdl_thresh - 8'd1;
      3:       return mdl_thresh;
      default: return LEVEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic build_profile();
    logic [LEVEL_W-1:0] lvl;
    lvl = pick_level();
    for (int i = 0; i < MAX_COLS; i++) begin
      if ($urandom_range(0, 3) == 0) lvl = pick_level();
      col_profile[i] = lvl;
    end
  endtask

  // Mostly the column's target, sometimes below it, rarely anything.
  function automatic logic [SAMPLE_W-1:0] shaped_sample();
    logic [LEVEL_W-1:0] p;
    p = col_profile[(col_cnt >= MAX_COLS) ? MAX_COLS - 1 : col_cnt];
    case ($urandom_range(0, 15))
      0:          return SAMPLE_W'($urandom_range(0, 255));
      1, 2, 3, 4: return SAMPLE_W'($urandom_range(0, p));
      default:    return p;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall per run word while rx_idle is set, plus an on-demand long hold
  // ---------------------------------------------------------------------------
  initial begin : rx_proc
    int gap;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready) && rx_hold_cycles == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Run checker
  // ---------------------------------------------------------------------------
  task automatic report_run(input string what, input run_t want, input run_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0s: exp strip %0d first %0d final %0d level %0d done %0d | got strip %0d first %0d final %0d level %0d done %0d",
               what, want.strip, want.first, want.final_col, want.level, want.done,
               got.strip, got.first, got.final_col, got.level, got.done);
  endtask

  always @(posedge clk) begin : run_checker
    run_t got;
    run_t want;
    if (!rst && out_valid && out_ready) begin
      got.strip     = strip_index;
      got.first     = run_first;
      got.final_col = run_final;
      got.level     = run_level;
      got.done      = strip_done;
      if (pending_runs.size() == 0) begin
        report_run("unexpected run word", '0, got);
      end else begin
        want = pending_runs.pop_front();
        if (got.strip !== want.strip || got.first !== want.first ||
            got.final_col !== want.final_col || got.level !== want.level ||
            got.done !== want.done)
          report_run("run mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_strip_max_run_length_encoder_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One-column strips at the reset threshold: reload on first row, the
  // threshold edge, and a single run per strip with strip_done set.
  task automatic test_single_column();
    logic [SAMPLE_W-1:0] s;
    write_reg(REG_ACTIVE_WIDTH, 10'd0);  // zero width acts as one column
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < ROWS; r++) begin
        if (r == 0) s = (k == 0) ? 8'd255 : 8'd0;
        else if (r == ROWS - 1) s = (k == 2) ? 8'd77 : 8'd76;
        else s = 8'd0;
        send_word(s, k == 0 && r == 0);
      end
    end
    drain_runs();
  endtask

  // Full-width strip on the cheap: first row at the oversize width, middle
  // rows at width 2, last row back at 512, so run columns reach 511.
  task automatic test_wide_strip();
    write_reg(REG_ZERO_THRESHOLD, CFG_W'($urandom_range(1, 254)));
    write_reg(REG_ACTIVE_WIDTH, 10'd1023);  // above range, acts as 512
    build_profile();
    for (int i = 0; i < MAX_COLS; i++) send_word(shaped_sample(), i == 0);
    drain_runs();
    write_reg(REG_ACTIVE_WIDTH, 10'd2);
    for (int i = 0; i < 2 * (ROWS - 2); i++) send_word(shaped_sample(), 1'b0);
    drain_runs();
    write_reg(REG_ACTIVE_WIDTH, 10'd512);
    for (int i = 0; i < MAX_COLS; i++) send_word(shaped_sample(), 1'b0);
    drain_runs();
  endtask

  // Receiver holds off long enough for the run queue to fill and stall input;
  // the sender then waits for every run before moving on.
  task automatic test_backpressure();
    write_reg(REG_ACTIVE_WIDTH, 10'd1);
    write_reg(REG_ZERO_THRESHOLD, CFG_W'($urandom_range(0, 255)));
    snd_idle       = 1'b0;
    rx_idle        = 1'b0;
    rx_hold_cycles = 300;
    for (int i = 0; i < 320; i++) send_word(SAMPLE_W'($urandom_range(0, 255)), i == 0);
    drain_runs();
  endtask

  // Phases of shaped traffic under changing config; phase ends fall mid-row,
  // so shrinking widths hit the wrap case. Rare frame starts cut rows short.
  task automatic test_random();
    int   start;
    int   phase;
    int   len;
    int   w;
    logic fs;
    start = words_sent;
    phase = 0;
    while (words_sent - start < RANDOM_WORDS) begin
      case (phase)
        0: begin
          write_reg(REG_ACTIVE_WIDTH, 10'd2);
          write_reg(REG_ZERO_THRESHOLD, 10'd255);
        end
        1: begin
          write_reg(REG_ACTIVE_WIDTH, 10'd0);
          write_reg(REG_ZERO_THRESHOLD, 10'd0);
        end
        2: write_reg(REG_ACTIVE_WIDTH, 10'd1023);
        default: begin
          if ($urandom_range(0, 3) != 0) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
            write_reg(REG_ACTIVE_WIDTH, CFG_W'(w));
          end
          if ($urandom_range(0, 2) == 0) write_reg(REG_ZERO_THRESHOLD, CFG_W'(pick_level()));
        end
      endcase
      len      = (phase == 2) ? 60 : $urandom_range(20, 150);
      snd_idle = ($urandom_range(0, 3) != 0);
      rx_idle  = ($urandom_range(0, 3) != 0);
      build_profile();
      for (int i = 0; i < len; i++) begin
        fs = (i == 0 && $urandom_range(0, 3) == 0) || ($urandom_range(0, 149) == 0);
        send_word(shaped_sample(), fs);
      end
      drain_runs();
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_column();
    test_wide_strip();
    test_backpressure();
    test_random();

    // bounded final wait, so leftovers get reported rather than timing out
    in_valid <= 1'b0;
    for (int i = 0; i < 2000 && pending_runs.size() != 0; i++) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
    if (pending_runs.size() != 0) begin
      $display("%0d expected run words never arrived", pending_runs.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("tb_strip_max_run_length_encoder_top OK");
    end else begin
      $display("tb_strip_max_run_length_encoder_top NOT OK");
    end
    $finish;
  end

endmodule
